// ----- sv/hsl_pkg.sv -----
// shared types for the rgb to hsl pixel pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package hsl_pkg;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } hsl_sector_type;

   typedef struct packed {
      logic gray;
      logic full;
   } hsl_flags_type;

endpackage

`default_nettype wire

// ----- sv/hsl_prep.sv -----
// front of the pipeline: max/min and hue sector, then lightness, divisors, dividends
// two register stages with valid/ready; depends on hsl_pkg
`default_nettype none

module hsl_prep
   import hsl_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [CHANNEL_BITS-1:0] red,
   input  logic [CHANNEL_BITS-1:0] green,
   input  logic [CHANNEL_BITS-1:0] blue,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [CHANNEL_BITS:0]   out_lightness,
   output logic [CHANNEL_BITS:0]   out_den,
   output logic [CHANNEL_BITS:0]   out_sat_rem,
   output logic [CHANNEL_BITS+2:0] out_hue_div,
   output logic [CHANNEL_BITS+2:0] out_hue_rem,
   output hsl_flags_type           out_flags
);

   localparam int CB = CHANNEL_BITS;
   localparam logic [CB:0] CH_MAX = {1'b0, {CB{1'b1}}};
   localparam logic [CB:0] TWO_MAX = {{CB{1'b1}}, 1'b0};

   // stage 1 registers
   logic                s1_valid_ff;
   logic [CB-1:0]       s1_max_ff, s1_max_in;
   logic [CB-1:0]       s1_min_ff, s1_min_in;
   logic [CB-1:0]       s1_x_ff, s1_x_in;
   logic [CB-1:0]       s1_y_ff, s1_y_in;
   hsl_sector_type      s1_sector_ff, s1_sector_in;

   // stage 2 registers
   logic                s2_valid_ff;
   logic [CB:0]         s2_light_ff, s2_light_in;
   logic [CB:0]         s2_den_ff, s2_den_in;
   logic [CB:0]         s2_d_ff, s2_d_in;
   logic [CB+2:0]       s2_div_ff, s2_div_in;
   logic [CB+2:0]       s2_num_ff, s2_num_in;
   hsl_flags_type       s2_flags_ff, s2_flags_in;

   logic                s1_load, s2_load;
   logic [CB-1:0]       diff;
   logic [CB+2:0]       d_ext, off_d;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   // sector select, ties go red then green
   always_comb begin
      priority if (red >= green && red >= blue) begin
         s1_sector_in = SECT_RED;
         s1_max_in    = red;
         s1_x_in      = green;
         s1_y_in      = blue;
      end else if (green >= blue) begin
         s1_sector_in = SECT_GREEN;
         s1_max_in    = green;
         s1_x_in      = blue;
         s1_y_in      = red;
      end else begin
         s1_sector_in = SECT_BLUE;
         s1_max_in    = blue;
         s1_x_in      = red;
         s1_y_in      = green;
      end
      s1_min_in = red;
      if (green < s1_min_in) begin
         s1_min_in = green;
      end
      if (blue < s1_min_in) begin
         s1_min_in = blue;
      end
   end

   always_comb begin
      s2_light_in = {1'b0, s1_max_ff} + {1'b0, s1_min_ff};
      diff        = s1_max_ff - s1_min_ff;
      s2_d_in     = {1'b0, diff};
      s2_den_in   = (s2_light_in <= CH_MAX) ? s2_light_in : TWO_MAX - s2_light_in;
      d_ext       = {3'b000, diff};
      s2_div_in   = (d_ext << 2) + (d_ext << 1);
      unique case (s1_sector_ff)
         SECT_RED:   off_d = (s1_x_ff >= s1_y_ff) ? '0 : s2_div_in;
         SECT_GREEN: off_d = d_ext << 1;
         SECT_BLUE:  off_d = d_ext << 2;
         default:    off_d = '0;
      endcase
      s2_num_in = off_d + {3'b000, s1_x_ff} - {3'b000, s1_y_ff};
      s2_flags_in.gray = (diff == '0);
      s2_flags_in.full = (s2_d_in == s2_den_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_max_ff    <= s1_max_in;
         s1_min_ff    <= s1_min_in;
         s1_x_ff      <= s1_x_in;
         s1_y_ff      <= s1_y_in;
         s1_sector_ff <= s1_sector_in;
      end
      if (s2_load) begin
         s2_light_ff <= s2_light_in;
         s2_den_ff   <= s2_den_in;
         s2_d_ff     <= s2_d_in;
         s2_div_ff   <= s2_div_in;
         s2_num_ff   <= s2_num_in;
         s2_flags_ff <= s2_flags_in;
      end
   end

   assign out_valid     = s2_valid_ff;
   assign out_lightness = s2_light_ff;
   assign out_den       = s2_den_ff;
   assign out_sat_rem   = s2_d_ff;
   assign out_hue_div   = s2_div_ff;
   assign out_hue_rem   = s2_num_ff;
   assign out_flags     = s2_flags_ff;

endmodule

`default_nettype wire

// ----- sv/hsl_div_step.sv -----
// one registered restoring-division step for both saturation and hue quotients
// one quotient bit per instance, valid/ready stage; depends on hsl_pkg
`default_nettype none

module hsl_div_step
   import hsl_pkg::*;
#(
   parameter int CHANNEL_BITS  = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [CHANNEL_BITS:0]    in_lightness,
   input  logic [CHANNEL_BITS:0]    in_den,
   input  logic [CHANNEL_BITS:0]    in_sat_rem,
   input  logic [FRACTION_BITS-1:0] in_sat_quo,
   input  logic [CHANNEL_BITS+2:0]  in_hue_div,
   input  logic [CHANNEL_BITS+2:0]  in_hue_rem,
   input  logic [FRACTION_BITS-1:0] in_hue_quo,
   input  hsl_flags_type            in_flags,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [CHANNEL_BITS:0]    out_lightness,
   output logic [CHANNEL_BITS:0]    out_den,
   output logic [CHANNEL_BITS:0]    out_sat_rem,
   output logic [FRACTION_BITS-1:0] out_sat_quo,
   output logic [CHANNEL_BITS+2:0]  out_hue_div,
   output logic [CHANNEL_BITS+2:0]  out_hue_rem,
   output logic [FRACTION_BITS-1:0] out_hue_quo,
   output hsl_flags_type            out_flags
);

   localparam int CB = CHANNEL_BITS;
   localparam int FB = FRACTION_BITS;

   logic            valid_ff;
   logic            load;
   logic [CB:0]     light_ff;
   logic [CB:0]     den_ff;
   logic [CB:0]     sat_rem_ff, sat_rem_in;
   logic [FB-1:0]   sat_quo_ff, sat_quo_in;
   logic [CB+2:0]   hue_div_ff;
   logic [CB+2:0]   hue_rem_ff, hue_rem_in;
   logic [FB-1:0]   hue_quo_ff, hue_quo_in;
   hsl_flags_type   flags_ff;

   logic [CB+1:0]   sat_shift, sat_sub, den_ext;
   logic [CB+3:0]   hue_shift, hue_sub, div_ext;
   logic            sat_ge, hue_ge;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      sat_shift  = {in_sat_rem, 1'b0};
      den_ext    = {1'b0, in_den};
      sat_ge     = (sat_shift >= den_ext);
      sat_sub    = sat_ge ? sat_shift - den_ext : sat_shift;
      sat_rem_in = sat_sub[CB:0];
      sat_quo_in = {in_sat_quo[FB-2:0], sat_ge};

      hue_shift  = {in_hue_rem, 1'b0};
      div_ext    = {1'b0, in_hue_div};
      hue_ge     = (hue_shift >= div_ext);
      hue_sub    = hue_ge ? hue_shift - div_ext : hue_shift;
      hue_rem_in = hue_sub[CB+2:0];
      hue_quo_in = {in_hue_quo[FB-2:0], hue_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         light_ff   <= in_lightness;
         den_ff     <= in_den;
         sat_rem_ff <= sat_rem_in;
         sat_quo_ff <= sat_quo_in;
         hue_div_ff <= in_hue_div;
         hue_rem_ff <= hue_rem_in;
         hue_quo_ff <= hue_quo_in;
         flags_ff   <= in_flags;
      end
   end

   assign out_valid     = valid_ff;
   assign out_lightness = light_ff;
   assign out_den       = den_ff;
   assign out_sat_rem   = sat_rem_ff;
   assign out_sat_quo   = sat_quo_ff;
   assign out_hue_div   = hue_div_ff;
   assign out_hue_rem   = hue_rem_ff;
   assign out_hue_quo   = hue_quo_ff;
   assign out_flags     = flags_ff;

endmodule

`default_nettype wire

// ----- sv/rgb_to_hsl_pixel_top.sv -----
// top level of the rgb to hsl pixel converter: prep stages, division chain, output register
// depends on hsl_pkg, hsl_prep, hsl_div_step
//
//  channel  ports                                   direction  word
//  req      req_valid req_ready req_*_in            in         one rgb pixel
//  rsp      rsp_valid rsp_ready rsp_hue/sat/light   out        hue, saturation, lightness
//
// one word in per clock when rsp is not stalled
// the division chain yields one quotient bit per stage
// every stage has its own valid bit; a stalled rsp fills empty stages before req_ready drops
// synchronous active-high reset clears all valid bits
`default_nettype none

module rgb_to_hsl_pixel_top
   import hsl_pkg::*;
#(
   parameter int CHANNEL_BITS  = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CHANNEL_BITS-1:0]  req_red_in,
   input  logic [CHANNEL_BITS-1:0]  req_green_in,
   input  logic [CHANNEL_BITS-1:0]  req_blue_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [FRACTION_BITS-1:0] rsp_hue,
   output logic [FRACTION_BITS-1:0] rsp_saturation,
   output logic [CHANNEL_BITS:0]    rsp_lightness
);

   localparam int CB = CHANNEL_BITS;
   localparam int FB = FRACTION_BITS;

   logic [FB:0]     valid_w;
   logic [FB:0]     ready_w;
   logic [CB:0]     light_w   [0:FB];
   logic [CB:0]     den_w     [0:FB];
   logic [CB:0]     sat_rem_w [0:FB];
   logic [FB-1:0]   sat_quo_w [0:FB];
   logic [CB+2:0]   hue_div_w [0:FB];
   logic [CB+2:0]   hue_rem_w [0:FB];
   logic [FB-1:0]   hue_quo_w [0:FB];
   hsl_flags_type   flags_w   [0:FB];

   logic            rsp_valid_ff;
   logic            out_load;
   logic [FB-1:0]   hue_ff, hue_in;
   logic [FB-1:0]   sat_ff, sat_in;
   logic [CB:0]     light_ff;

   hsl_prep #(
      .CHANNEL_BITS(CB)
   ) u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .red           (req_red_in),
      .green         (req_green_in),
      .blue          (req_blue_in),
      .out_valid     (valid_w[0]),
      .out_ready     (ready_w[0]),
      .out_lightness (light_w[0]),
      .out_den       (den_w[0]),
      .out_sat_rem   (sat_rem_w[0]),
      .out_hue_div   (hue_div_w[0]),
      .out_hue_rem   (hue_rem_w[0]),
      .out_flags     (flags_w[0])
   );

   assign sat_quo_w[0] = '0;
   assign hue_quo_w[0] = '0;

   for (genvar i = 0; i < FB; i++) begin : g_div
      hsl_div_step #(
         .CHANNEL_BITS (CB),
         .FRACTION_BITS(FB)
      ) u_step (
         .clock         (clock),
         .reset         (reset),
         .in_valid      (valid_w[i]),
         .in_ready      (ready_w[i]),
         .in_lightness  (light_w[i]),
         .in_den        (den_w[i]),
         .in_sat_rem    (sat_rem_w[i]),
         .in_sat_quo    (sat_quo_w[i]),
         .in_hue_div    (hue_div_w[i]),
         .in_hue_rem    (hue_rem_w[i]),
         .in_hue_quo    (hue_quo_w[i]),
         .in_flags      (flags_w[i]),
         .out_valid     (valid_w[i+1]),
         .out_ready     (ready_w[i+1]),
         .out_lightness (light_w[i+1]),
         .out_den       (den_w[i+1]),
         .out_sat_rem   (sat_rem_w[i+1]),
         .out_sat_quo   (sat_quo_w[i+1]),
         .out_hue_div   (hue_div_w[i+1]),
         .out_hue_rem   (hue_rem_w[i+1]),
         .out_hue_quo   (hue_quo_w[i+1]),
         .out_flags     (flags_w[i+1])
      );
   end

   // output register
   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign ready_w[FB] = out_load;

   always_comb begin
      priority if (flags_w[FB].gray) begin
         hue_in = '0;
         sat_in = '0;
      end else if (flags_w[FB].full) begin
         hue_in = hue_quo_w[FB];
         sat_in = '1;
      end else begin
         hue_in = hue_quo_w[FB];
         sat_in = sat_quo_w[FB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= valid_w[FB];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_w[FB];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = light_ff;

   // input backpressure only when every stage is full and the output is stalled
   a_full_chain : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low while the pipeline still has room");

   // hue dividend stays below its divisor for colored pixels
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      valid_w[0] && !flags_w[0].gray |-> hue_rem_w[0] < hue_div_w[0])
      else $error("hue dividend not below six times the channel spread");

   // saturation dividend never exceeds its divisor
   a_sat_range : assert property (@(posedge clock) disable iff (reset)
      valid_w[0] && !flags_w[0].gray |-> sat_rem_w[0] <= den_w[0])
      else $error("saturation dividend exceeds its divisor");

endmodule

`default_nettype wire

// ----- test/tb_rgb_to_hsl_pixel_top.sv -----
// testbench for rgb_to_hsl_pixel_top: corner pixels, random pixels, output stall, input pause
// depends on hsl_pkg and rgb_to_hsl_pixel_top; checks every result word against its own predictor
`default_nettype none

module tb_rgb_to_hsl_pixel_top;
   import hsl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 16;
   localparam int PIPE_LATENCY  = FRACTION_BITS + 3;
   localparam int MAX_WAIT      = 14;
   localparam int HOLD_CYCLES   = 150;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_PIXELS = 1500;

   localparam longint unsigned CH_MAX   = (64'd1 << CHANNEL_BITS) - 64'd1;
   localparam longint unsigned FRAC_MAX = (64'd1 << FRACTION_BITS) - 64'd1;

   typedef logic [CHANNEL_BITS-1:0] channel_type;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue;
      logic [FRACTION_BITS-1:0] saturation;
      logic [CHANNEL_BITS:0]    lightness;
   } hsl_word_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   channel_type              req_red_in;
   channel_type              req_green_in;
   channel_type              req_blue_in;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [FRACTION_BITS-1:0] rsp_hue;
   logic [FRACTION_BITS-1:0] rsp_saturation;
   logic [CHANNEL_BITS:0]    rsp_lightness;

   hsl_word_type pending_hsl[$];
   int        error_count = 0;
   int        idle_cycles = 0;
   bit        tx_idle = 1'b0;
   bit        rx_idle = 1'b0;
   bit        rsp_hold_pending = 1'b0;

   rgb_to_hsl_pixel_top #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic hsl_word_type predict_hsl(input channel_type r, input channel_type g,
                                                input channel_type b);
      longint unsigned rr, gg, bb;
      longint unsigned mx, mn, sum, d, den, num, quot;
      hsl_sector_type  sector;
      hsl_word_type    w;
      rr = 64'(r);
      gg = 64'(g);
      bb = 64'(b);
      mx = rr;
      mn = rr;
      sector = SECT_RED;
      if (gg > mx) begin
         mx = gg;
         sector = SECT_GREEN;
      end
      if (bb > mx) begin
         mx = bb;
         sector = SECT_BLUE;
      end
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      sum = mx + mn;
      w.lightness = sum[CHANNEL_BITS:0];
      w.hue = '0;
      w.saturation = '0;
      if (mx == mn) return w;
      d = mx - mn;
      den = (sum <= CH_MAX) ? sum : (64'd2 * CH_MAX - sum);
      quot = (d << FRACTION_BITS) / den;
      w.saturation = (quot > FRAC_MAX) ? FRAC_MAX[FRACTION_BITS-1:0] : quot[FRACTION_BITS-1:0];
      case (sector)
         SECT_RED: begin
            num = (gg >= bb) ? (gg - bb) : (64'd6 * d - (bb - gg));
         end
         SECT_GREEN: begin
            num = 64'd2 * d + bb - rr;
         end
         default: begin
            num = 64'd4 * d + rr - gg;
         end
      endcase
      quot = (num << FRACTION_BITS) / (64'd6 * d);
      w.hue = (quot > FRAC_MAX) ? FRAC_MAX[FRACTION_BITS-1:0] : quot[FRACTION_BITS-1:0];
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_pixel(input channel_type r, input channel_type g, input channel_type b);
      int gap;
      gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_hsl.push_back(predict_hsl(r, g, b));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_hsl.size() != 0) @(negedge clock);
      repeat (2 * PIPE_LATENCY) @(negedge clock);
   endtask

   task automatic send_shaped_pixel();
      channel_type r, g, b;
      int          pick;
      r = channel_type'($urandom);
      g = channel_type'($urandom);
      b = channel_type'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            g = r;
            b = r;
         end
         1: begin
            if ($urandom_range(0, 1)) g = '0; else g = CH_MAX[CHANNEL_BITS-1:0];
         end
         2: begin
            if ($urandom_range(0, 1)) g = r; else b = g;
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   task automatic test_corner_pixels();
      logic [23:0] corner_list[22] = '{
         24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
         24'hffff00, 24'h00ffff, 24'hff00ff, 24'hc80a32, 24'hc8320a, 24'h0ac832,
         24'h32c80a, 24'h320ac8, 24'h0a32c8, 24'h010000, 24'hfffefe, 24'h807f7f,
         24'h80807f, 24'h818080, 24'haa5500, 24'h55aa55
      };
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      foreach (corner_list[i])
         send_pixel(corner_list[i][23:16], corner_list[i][15:8], corner_list[i][7:0]);
      drain_results();
   endtask

   task automatic test_random_pixels();
      for (int chunk = 0; chunk < RANDOM_PIXELS / 100; chunk++) begin
         tx_idle = 1'($urandom_range(0, 1));
         rx_idle = 1'($urandom_range(0, 1));
         repeat (100) send_shaped_pixel();
         if (chunk % 5 == 4) drain_results();
      end
      drain_results();
   endtask

   task automatic test_output_stall();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      rsp_hold_pending = 1'b1;
      repeat (80) send_shaped_pixel();
      drain_results();
   endtask

   task automatic test_input_pause();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (30) send_shaped_pixel();
      drain_results();
      repeat (30) send_shaped_pixel();
      drain_results();
   endtask

   // result side ready with random stalls and an occasional long hold
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_pending = 1'b0;
         end
         gap = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      hsl_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hsl.size() == 0) begin
            $display("%0t unexpected word hue %0d saturation %0d lightness %0d",
                     $time, rsp_hue, rsp_saturation, rsp_lightness);
            error_count++;
         end else begin
            want = pending_hsl.pop_front();
            if (rsp_hue !== want.hue) begin
               $display("%0t hue expected %0d actual %0d", $time, want.hue, rsp_hue);
               error_count++;
            end
            if (rsp_saturation !== want.saturation) begin
               $display("%0t saturation expected %0d actual %0d",
                        $time, want.saturation, rsp_saturation);
               error_count++;
            end
            if (rsp_lightness !== want.lightness) begin
               $display("%0t lightness expected %0d actual %0d",
                        $time, want.lightness, rsp_lightness);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("rgb_to_hsl_pixel_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_corner_pixels();
      test_random_pixels();
      test_output_stall();
      test_input_pause();
      if (pending_hsl.size() != 0) begin
         $display("%0t %0d words never arrived", $time, pending_hsl.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("rgb_to_hsl_pixel_top: match");
      end else begin
         $display("rgb_to_hsl_pixel_top: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/hsl_pkg.sv
sv/hsl_prep.sv
sv/hsl_div_step.sv
sv/rgb_to_hsl_pixel_top.sv
test/tb_rgb_to_hsl_pixel_top.sv
